>>> rtl/core/tpit_pkg.sv
// Shared widths, register indexes and the configuration bundle of the tip point test.
`timescale 1ns / 1ps

package tpit_pkg;

    // Lengths are unsigned Q15.16 in 31 bits; base z is signed in 32 bits.
    localparam int LEN_W   = 31;
    localparam int BZ_W    = 32;
    localparam int TOL_W   = 16;
    localparam int SQ_W    = 2 * LEN_W;
    localparam int R2_W    = SQ_W + 1;
    localparam int CAP_W   = R2_W + 1;
    localparam int LO_W    = 32;
    localparam int R2H_W   = R2_W - LO_W;
    localparam int SQH_W   = SQ_W - LO_W;
    localparam int PROD_W  = 2 * R2_W;

    // Configuration port.
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 32;

    localparam logic [CFG_IW-1:0] CFG_FRUSTUM_HEIGHT = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_BASE_RADIUS    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_TOP_RADIUS     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BASE_Z         = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CAP_TOLERANCE  = 3'd4;

    // Edges from the accepting edge to the edge that loads the result strobe.
    localparam int LATENCY = 7;

    typedef struct packed {
        logic [LEN_W-1:0] fh;
        logic [LEN_W-1:0] rb;
        logic [LEN_W-1:0] rt;
        logic [BZ_W-1:0]  bz;
        logic [TOL_W-1:0] tol;
        logic [SQ_W-1:0]  fh_sq;
        logic [SQ_W-1:0]  rt_sq;
        logic [BZ_W-1:0]  fh_rt;
    } t_cfg;

endpackage

>>> rtl/core/tip_point_inside_test.sv
// Top level of the tip point test: a pipelined inside test of points against a needle tip.
`timescale 1ns / 1ps
//
// A point (i_point_x, i_point_y, i_point_z, signed fixed point) is taken as one beat at
// a rising edge where start is high and busy is low. busy is high only from reset until
// the first edge after reset is released, so a new point may be started in every cycle.
// The answer appears on o_inside_res with o_done high for exactly one cycle, in the
// order the points came in. Throughput is one point per cycle; the datapath has eight
// register stages (box check, split into frustum and cap, products, and a 126-bit
// compare made from 32 by 32 bit partial products).
// The five shape registers are written through i_cfg_we, i_cfg_idx and i_cfg_wdata, one
// register per edge; the user must write them only while no point is in flight, which the
// block does not enforce; writes to unused indexes are dropped. Squares of the frustum
// height and top radius follow a write in the next cycle. Reset is synchronous and clears
// the shape registers to unit sizes and the pipeline valid bits, so no stale result comes
// out. The receiver cannot stall: each result is taken in the cycle it is shown.

module tip_point_inside_test import tpit_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic                          i_cfg_we,
    input  logic [CFG_IW-1:0]             i_cfg_idx,
    input  logic [CFG_DW-1:0]             i_cfg_wdata,
    output logic                          o_done,
    output logic                          o_inside_res
);

    // Room for the coordinate, the base z and the difference of the two.
    localparam int XW = ((COORD_WIDTH > BZ_W) ? COORD_WIDTH : BZ_W) + 2;

    t_cfg cfg;

    tpit_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Control.
    logic               r_run;
    logic [LATENCY-1:0] r_vld;
    logic               r_done;
    logic               r_res;
    logic               accept;

    assign busy   = !r_run;
    assign accept = start && r_run;

    // Stage 1: input beat.
    logic signed [COORD_WIDTH-1:0] r_s1_x, r_s1_y, r_s1_z;

    // Stage 2: bounding box, magnitudes, height above base.
    logic signed [XW-1:0] x_e, y_e, z_e, rb_e, bz_e, dz_e, fhrt_e, ax_e, ay_e;
    logic                 n_s2_in;
    logic [LEN_W-1:0]     n_s2_ax, n_s2_ay;
    logic [BZ_W-1:0]      n_s2_dz;
    logic                 r_s2_in;
    logic [LEN_W-1:0]     r_s2_ax, r_s2_ay;
    logic [BZ_W-1:0]      r_s2_dz;

    // Stage 3: frustum or cap, cap height guard, squares of x and y.
    logic [BZ_W-1:0]      h_w;
    logic                 n_s3_fr, n_s3_capok;
    logic [LEN_W-1:0]     n_s3_fmd, n_s3_h;
    logic [SQ_W-1:0]      n_s3_ax2, n_s3_ay2;
    logic                 r_s3_in, r_s3_fr, r_s3_capok;
    logic [LEN_W-1:0]     r_s3_fmd, r_s3_dz, r_s3_h;
    logic [SQ_W-1:0]      r_s3_ax2, r_s3_ay2;

    // Stage 4: radius products, radial square sum, cap height square.
    logic [SQ_W-1:0]      n_s4_pb, n_s4_pt, n_s4_h2;
    logic [R2_W-1:0]      n_s4_r2;
    logic                 r_s4_in, r_s4_fr, r_s4_capok;
    logic [SQ_W-1:0]      r_s4_pb, r_s4_pt, r_s4_h2;
    logic [R2_W-1:0]      r_s4_r2;

    // Stage 5: scaled radius, cap verdict, partial products of r2 * fh^2.
    logic [R2_W-1:0]            n_s5_rzf;
    logic                       n_s5_cap;
    logic [R2H_W+SQH_W-1:0]     n_s5_phh;
    logic [R2H_W+LO_W-1:0]      n_s5_phl;
    logic [LO_W+SQH_W-1:0]      n_s5_plh;
    logic [2*LO_W-1:0]          n_s5_pll;
    logic                       r_s5_in, r_s5_fr, r_s5_cap;
    logic [R2_W-1:0]            r_s5_rzf;
    logic [R2H_W+SQH_W-1:0]     r_s5_phh;
    logic [R2H_W+LO_W-1:0]      r_s5_phl;
    logic [LO_W+SQH_W-1:0]      r_s5_plh;
    logic [2*LO_W-1:0]          r_s5_pll;

    // Stage 6: left side summed, partial products of the scaled radius square.
    logic [R2H_W-1:0]           rzf_hi;
    logic [LO_W-1:0]            rzf_lo;
    logic [PROD_W-1:0]          n_s6_lhs;
    logic [2*R2H_W-1:0]         n_s6_qhh;
    logic [R2H_W+LO_W-1:0]      n_s6_qhl;
    logic [2*LO_W-1:0]          n_s6_qll;
    logic                       r_s6_in, r_s6_fr, r_s6_cap;
    logic [PROD_W-1:0]          r_s6_lhs;
    logic [2*R2H_W-1:0]         r_s6_qhh;
    logic [R2H_W+LO_W-1:0]      r_s6_qhl;
    logic [2*LO_W-1:0]          r_s6_qll;

    // Stage 7: right side summed.
    logic [PROD_W-1:0]          n_s7_rhs;
    logic                       r_s7_in, r_s7_fr, r_s7_cap;
    logic [PROD_W-1:0]          r_s7_lhs, r_s7_rhs;

    logic                       n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_vld  <= '0;
            r_done <= 1'b0;
            r_res  <= 1'b0;
        end else begin
            r_run  <= 1'b1;
            r_vld  <= {r_vld[LATENCY-2:0], accept};
            r_done <= r_vld[LATENCY-1];
            r_res  <= r_vld[LATENCY-1] && n_res;
        end
    end

    assign o_done       = r_done;
    assign o_inside_res = r_res;

    always_comb begin
        x_e    = XW'(r_s1_x);
        y_e    = XW'(r_s1_y);
        z_e    = XW'(r_s1_z);
        rb_e   = $signed(XW'(cfg.rb));
        bz_e   = XW'($signed(cfg.bz));
        fhrt_e = $signed(XW'(cfg.fh_rt));
        dz_e   = z_e - bz_e;
        ax_e   = x_e[XW-1] ? -x_e : x_e;
        ay_e   = y_e[XW-1] ? -y_e : y_e;
        n_s2_in = (x_e >= -rb_e) && (x_e <= rb_e) &&
                  (y_e >= -rb_e) && (y_e <= rb_e) &&
                  !dz_e[XW-1] && (dz_e <= fhrt_e);
        // Inside the box both magnitudes are at most the base radius, so 31 bits hold them.
        n_s2_ax = ax_e[LEN_W-1:0];
        n_s2_ay = ay_e[LEN_W-1:0];
        n_s2_dz = dz_e[BZ_W-1:0];
    end

    always_comb begin
        n_s3_fr    = (cfg.fh != '0) && (r_s2_dz <= BZ_W'(cfg.fh));
        n_s3_fmd   = cfg.fh - r_s2_dz[LEN_W-1:0];
        // In the cap the height above the frustum never exceeds the top radius.
        h_w        = r_s2_dz - BZ_W'(cfg.fh);
        n_s3_h     = h_w[LEN_W-1:0];
        n_s3_capok = (BZ_W'(n_s3_h) + BZ_W'(cfg.tol)) <= BZ_W'(cfg.rt);
        n_s3_ax2   = SQ_W'(r_s2_ax) * SQ_W'(r_s2_ax);
        n_s3_ay2   = SQ_W'(r_s2_ay) * SQ_W'(r_s2_ay);
    end

    always_comb begin
        n_s4_pb = SQ_W'(cfg.rb) * SQ_W'(r_s3_fmd);
        n_s4_pt = SQ_W'(cfg.rt) * SQ_W'(r_s3_dz);
        n_s4_h2 = SQ_W'(r_s3_h) * SQ_W'(r_s3_h);
        n_s4_r2 = R2_W'(r_s3_ax2) + R2_W'(r_s3_ay2);
    end

    always_comb begin
        n_s5_rzf = R2_W'(r_s4_pb) + R2_W'(r_s4_pt);
        n_s5_cap = r_s4_capok &&
                   ((CAP_W'(r_s4_r2) + CAP_W'(r_s4_h2)) <= CAP_W'(cfg.rt_sq));
        n_s5_phh = (R2H_W+SQH_W)'(r_s4_r2[R2_W-1:LO_W]) *
                   (R2H_W+SQH_W)'(cfg.fh_sq[SQ_W-1:LO_W]);
        n_s5_phl = (R2H_W+LO_W)'(r_s4_r2[R2_W-1:LO_W]) *
                   (R2H_W+LO_W)'(cfg.fh_sq[LO_W-1:0]);
        n_s5_plh = (LO_W+SQH_W)'(r_s4_r2[LO_W-1:0]) *
                   (LO_W+SQH_W)'(cfg.fh_sq[SQ_W-1:LO_W]);
        n_s5_pll = (2*LO_W)'(r_s4_r2[LO_W-1:0]) * (2*LO_W)'(cfg.fh_sq[LO_W-1:0]);
    end

    always_comb begin
        rzf_hi   = r_s5_rzf[R2_W-1:LO_W];
        rzf_lo   = r_s5_rzf[LO_W-1:0];
        n_s6_lhs = (PROD_W'(r_s5_phh) << (2 * LO_W)) +
                   ((PROD_W'(r_s5_phl) + PROD_W'(r_s5_plh)) << LO_W) +
                   PROD_W'(r_s5_pll);
        n_s6_qhh = (2*R2H_W)'(rzf_hi) * (2*R2H_W)'(rzf_hi);
        n_s6_qhl = (R2H_W+LO_W)'(rzf_hi) * (R2H_W+LO_W)'(rzf_lo);
        n_s6_qll = (2*LO_W)'(rzf_lo) * (2*LO_W)'(rzf_lo);
    end

    always_comb begin
        // The cross term appears twice in the square, hence one extra bit of shift.
        n_s7_rhs = (PROD_W'(r_s6_qhh) << (2 * LO_W)) +
                   (PROD_W'(r_s6_qhl) << (LO_W + 1)) +
                   PROD_W'(r_s6_qll);
    end

    always_comb begin
        n_res = r_s7_in && (r_s7_fr ? (r_s7_lhs <= r_s7_rhs) : r_s7_cap);
    end

    always_ff @(posedge i_clk) begin
        r_s1_x     <= i_point_x;
        r_s1_y     <= i_point_y;
        r_s1_z     <= i_point_z;

        r_s2_in    <= n_s2_in;
        r_s2_ax    <= n_s2_ax;
        r_s2_ay    <= n_s2_ay;
        r_s2_dz    <= n_s2_dz;

        r_s3_in    <= r_s2_in;
        r_s3_fr    <= n_s3_fr;
        r_s3_capok <= n_s3_capok;
        r_s3_fmd   <= n_s3_fmd;
        r_s3_dz    <= r_s2_dz[LEN_W-1:0];
        r_s3_h     <= n_s3_h;
        r_s3_ax2   <= n_s3_ax2;
        r_s3_ay2   <= n_s3_ay2;

        r_s4_in    <= r_s3_in;
        r_s4_fr    <= r_s3_fr;
        r_s4_capok <= r_s3_capok;
        r_s4_pb    <= n_s4_pb;
        r_s4_pt    <= n_s4_pt;
        r_s4_h2    <= n_s4_h2;
        r_s4_r2    <= n_s4_r2;

        r_s5_in    <= r_s4_in;
        r_s5_fr    <= r_s4_fr;
        r_s5_cap   <= n_s5_cap;
        r_s5_rzf   <= n_s5_rzf;
        r_s5_phh   <= n_s5_phh;
        r_s5_phl   <= n_s5_phl;
        r_s5_plh   <= n_s5_plh;
        r_s5_pll   <= n_s5_pll;

        r_s6_in    <= r_s5_in;
        r_s6_fr    <= r_s5_fr;
        r_s6_cap   <= r_s5_cap;
        r_s6_lhs   <= n_s6_lhs;
        r_s6_qhh   <= n_s6_qhh;
        r_s6_qhl   <= n_s6_qhl;
        r_s6_qll   <= n_s6_qll;

        r_s7_in    <= r_s6_in;
        r_s7_fr    <= r_s6_fr;
        r_s7_cap   <= r_s6_cap;
        r_s7_lhs   <= r_s6_lhs;
        r_s7_rhs   <= n_s7_rhs;
    end

endmodule

>>> rtl/core/tpit_cfg.sv
// Configuration registers of the tip point test and the values derived from them.
`timescale 1ns / 1ps

module tpit_cfg import tpit_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    output t_cfg              o_cfg
);

    logic [LEN_W-1:0] r_fh;
    logic [LEN_W-1:0] r_rb;
    logic [LEN_W-1:0] r_rt;
    logic [BZ_W-1:0]  r_bz;
    logic [TOL_W-1:0] r_tol;
    logic [SQ_W-1:0]  r_fh_sq;
    logic [SQ_W-1:0]  r_rt_sq;
    logic [BZ_W-1:0]  r_fh_rt;

    logic [SQ_W-1:0]  n_fh_sq;
    logic [SQ_W-1:0]  n_rt_sq;
    logic [BZ_W-1:0]  n_fh_rt;

    // Squares and the box height are registered and follow the registers in the next cycle.
    always_comb begin
        n_fh_sq = SQ_W'(r_fh) * SQ_W'(r_fh);
        n_rt_sq = SQ_W'(r_rt) * SQ_W'(r_rt);
        n_fh_rt = BZ_W'(r_fh) + BZ_W'(r_rt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fh    <= LEN_W'(1) << FRAC_BITS;
            r_rb    <= LEN_W'(1) << FRAC_BITS;
            r_rt    <= LEN_W'(1) << FRAC_BITS;
            r_bz    <= '0;
            r_tol   <= TOL_W'(1);
            r_fh_sq <= SQ_W'(1) << (2 * FRAC_BITS);
            r_rt_sq <= SQ_W'(1) << (2 * FRAC_BITS);
            r_fh_rt <= BZ_W'(2) << FRAC_BITS;
        end else begin
            r_fh_sq <= n_fh_sq;
            r_rt_sq <= n_rt_sq;
            r_fh_rt <= n_fh_rt;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRUSTUM_HEIGHT: r_fh  <= i_cfg_wdata[LEN_W-1:0];
                    CFG_BASE_RADIUS:    r_rb  <= i_cfg_wdata[LEN_W-1:0];
                    CFG_TOP_RADIUS:     r_rt  <= i_cfg_wdata[LEN_W-1:0];
                    CFG_BASE_Z:         r_bz  <= i_cfg_wdata[BZ_W-1:0];
                    CFG_CAP_TOLERANCE:  r_tol <= i_cfg_wdata[TOL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_cfg.fh    = r_fh;
        o_cfg.rb    = r_rb;
        o_cfg.rt    = r_rt;
        o_cfg.bz    = r_bz;
        o_cfg.tol   = r_tol;
        o_cfg.fh_sq = r_fh_sq;
        o_cfg.rt_sq = r_rt_sq;
        o_cfg.fh_rt = r_fh_rt;
    end

endmodule

>>> rtl/core/tpit_chk.sv
// Port checker of the tip point test and its bind to the top level.
`timescale 1ns / 1ps

module tpit_chk import tpit_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_inside_res
);

    // The strobe is loaded through the valid shift register and is seen at the edge after it is loaded.
    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(LATENCY + 1) o_done)
        else $error("accepted point produced no result at the expected cycle");

    // Every result strobe has a matching accepted point.
    a_result_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY + 1))
        else $error("result shown without a matching accepted point");

    // The answer bit is quiet between results.
    a_quiet_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> !o_inside_res)
        else $error("inside flag high without a result strobe");

    // Reset leaves the block refusing points and showing no result.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_done))
        else $error("block not quiet after reset");

endmodule

bind tip_point_inside_test tpit_chk u_tpit_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_inside_res (o_inside_res)
);
